[hw/rtl/hub_weighted_pair_score_assert.svh]
// ----------------------------------------------------------------------------
// Hub weighted pair score assertion macros
// Concurrent assertion wrappers shared by the queue and back end; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef HUB_WEIGHTED_PAIR_SCORE_ASSERT_SVH
`define HUB_WEIGHTED_PAIR_SCORE_ASSERT_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define HWPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hwps assertion failed");
// Same-cycle implication.
`define HWPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hwps implication failed");
// Next-cycle implication.
`define HWPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hwps next-cycle implication failed");
`else
`define HWPS_ASSERT(lbl, clk, rst_n, prop)
`define HWPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HWPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/hwps_pkg.sv]
// ----------------------------------------------------------------------------
// Hub weighted pair score package
// Shared widths, codes and transfer types of the pair score block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hwps_pkg;

  // Field widths.
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned SLOT_W   = 7;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned SCORE_W  = 48;
  localparam int unsigned WEIGHT_W = 40;
  localparam int unsigned GVAL_W   = 17;
  localparam int unsigned SQ_W     = 32;
  localparam int unsigned DIST_W   = 33;
  localparam int unsigned RSQ_W    = 32;
  localparam int unsigned DIV_W    = 63;

  // Mode codes of an input item.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Squared hub radius floor (2^-12 in units of 2^-32).
  localparam logic [RSQ_W-1:0] RSQ_FLOOR = 32'h0010_0000;
  // Upper part of the weight dividend 2^79, seen before the quotient bits.
  localparam logic [DIV_W-1:0] DIV_REM_INIT = 63'h0000_0080_0000_0000;
  localparam logic [5:0]       DIV_LAST     = 6'd39;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  typedef enum logic {
    OP_LOAD,
    OP_QUERY
  } cmd_op_e;

  typedef struct packed {
    logic                      mode;
    logic signed [COORD_W-1:0] node_a_x;
    logic signed [COORD_W-1:0] node_a_y;
    logic signed [COORD_W-1:0] node_b_x;
    logic signed [COORD_W-1:0] node_b_y;
    logic [SLOT_W-1:0]         hub_slot;
    logic signed [COORD_W-1:0] hub_x_value;
    logic signed [COORD_W-1:0] hub_y_value;
  } in_item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               saturated;
  } out_item_t;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    cmd_op_e                   op;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] hub_x;
    logic signed [COORD_W-1:0] hub_y;
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
  } cmd_t;

  // Weight unit request and response.
  typedef struct packed {
    logic                      start;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } wreq_t;

  typedef struct packed {
    logic                done;
    logic [WEIGHT_W-1:0] weight;
  } wrsp_t;

endpackage

[hw/rtl/hwps_queue.sv]
// ----------------------------------------------------------------------------
// Hub weighted pair score command queue
// Two-entry FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hub_weighted_pair_score_assert.svh"

module hwps_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hwps_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output hwps_pkg::cmd_t head_o
);

  localparam int unsigned DEPTH = 2;

  hwps_pkg::cmd_t mem_q [DEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign full_o  = (cnt_q == 2'(DEPTH));
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  `HWPS_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= 2'(DEPTH))
  `HWPS_ASSERT_IMP(a_pop_nonempty, clk_i, rst_ni, pop_i, cnt_q != 2'd0)
  `HWPS_ASSERT_IMP(a_push_room, clk_i, rst_ni, push_i, cnt_q != 2'(DEPTH))
  `HWPS_ASSERT_NXT(a_push_grows, clk_i, rst_ni, push_i && !pop_i,
                   cnt_q == $past(cnt_q) + 2'd1)

endmodule

[hw/rtl/hwps_front.sv]
// ----------------------------------------------------------------------------
// Hub weighted pair score front end
// Accepts input items, classifies them and drops loads aimed past the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hwps_front #(
  parameter int unsigned MAX_HUBS = 128
) (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hwps_pkg::in_item_t in_item_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output hwps_pkg::cmd_t     q_data_o
);

  logic [31:0] slot_ext;
  logic        is_query;
  logic        keep;

  // Classify the item and decide whether it reaches the back end.
  always_comb begin
    slot_ext = 32'(in_item_i.hub_slot);
    is_query = (in_item_i.mode == hwps_pkg::MODE_QUERY);
    keep     = is_query || (slot_ext < MAX_HUBS);

    q_data_o.op    = is_query ? hwps_pkg::OP_QUERY : hwps_pkg::OP_LOAD;
    q_data_o.slot  = in_item_i.hub_slot;
    q_data_o.hub_x = in_item_i.hub_x_value;
    q_data_o.hub_y = in_item_i.hub_y_value;
    q_data_o.a_x   = in_item_i.node_a_x;
    q_data_o.a_y   = in_item_i.node_a_y;
    q_data_o.b_x   = in_item_i.node_b_x;
    q_data_o.b_y   = in_item_i.node_b_y;
  end

  // A transfer happens when an item is valid and the queue has room.
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && keep;

endmodule

[hw/rtl/hwps_weight.sv]
// ----------------------------------------------------------------------------
// Hub weighted pair score weight unit
// Computes floor(2^79 / r2^2) with a floored r2, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hwps_weight (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hwps_pkg::wreq_t req_i,
  output hwps_pkg::wrsp_t rsp_o
);

  localparam logic [2:0] W_IDLE = 3'd0;
  localparam logic [2:0] W_SQ   = 3'd1;
  localparam logic [2:0] W_R2   = 3'd2;
  localparam logic [2:0] W_MUL  = 3'd3;
  localparam logic [2:0] W_DIV  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [5:0] step_q, step_d;
  logic       done_q, done_d;

  logic signed [hwps_pkg::COORD_W-1:0] x_q, y_q;
  logic [hwps_pkg::SQ_W-1:0]           xx_q, yy_q;
  logic [hwps_pkg::RSQ_W-1:0]          r2_q;
  logic [hwps_pkg::DIV_W-1:0]          d_q, rem_q;
  logic [hwps_pkg::WEIGHT_W-1:0]       quo_q;

  logic signed [31:0]         xsq, ysq;
  logic [hwps_pkg::RSQ_W-1:0] r2_sum;
  logic [63:0]                dsq;
  logic [63:0]                rem_sh;
  logic [64:0]                diff;
  logic                       ge;

  // Datapath of the current step.
  always_comb begin
    xsq    = 32'(x_q) * 32'(x_q);
    ysq    = 32'(y_q) * 32'(y_q);
    r2_sum = xx_q + yy_q;
    dsq    = 64'(r2_q) * 64'(r2_q);
    rem_sh = {rem_q, 1'b0};
    diff   = {1'b0, rem_sh} - {2'b00, d_q};
    ge     = !diff[64];
  end

  // Step sequencer.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    done_d  = 1'b0;
    case (state_q)
      W_IDLE: begin
        if (req_i.start) begin
          state_d = W_SQ;
        end
      end
      W_SQ:  state_d = W_R2;
      W_R2:  state_d = W_MUL;
      W_MUL: begin
        state_d = W_DIV;
        step_d  = 6'd0;
      end
      W_DIV: begin
        step_d = step_q + 6'd1;
        if (step_q == hwps_pkg::DIV_LAST) begin
          state_d = W_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      step_q  <= 6'd0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  // Operand and quotient registers.
  always_ff @(posedge clk_i) begin
    if (state_q == W_IDLE && req_i.start) begin
      x_q <= req_i.x;
      y_q <= req_i.y;
    end
    if (state_q == W_SQ) begin
      xx_q <= xsq;
      yy_q <= ysq;
    end
    if (state_q == W_R2) begin
      r2_q <= (r2_sum < hwps_pkg::RSQ_FLOOR) ? hwps_pkg::RSQ_FLOOR : r2_sum;
    end
    if (state_q == W_MUL) begin
      d_q   <= dsq[hwps_pkg::DIV_W-1:0];
      rem_q <= hwps_pkg::DIV_REM_INIT;
      quo_q <= '0;
    end
    if (state_q == W_DIV) begin
      rem_q <= ge ? diff[hwps_pkg::DIV_W-1:0] : rem_sh[hwps_pkg::DIV_W-1:0];
      quo_q <= {quo_q[hwps_pkg::WEIGHT_W-2:0], ge};
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.weight = quo_q;

endmodule

[hw/rtl/hwps_exp_rom.sv]
// ----------------------------------------------------------------------------
// Hub weighted pair score exponential table
// Dual-read ROM of exp(-20*i/depth) in Q16, built at elaboration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hwps_exp_rom #(
  parameter int unsigned EXP_TABLE_DEPTH = 1024
) (
  input  logic                               clk_i,
  input  logic [$clog2(EXP_TABLE_DEPTH)-1:0] idx_a_i,
  input  logic [$clog2(EXP_TABLE_DEPTH)-1:0] idx_b_i,
  output logic [hwps_pkg::GVAL_W-1:0]        val_a_o,
  output logic [hwps_pkg::GVAL_W-1:0]        val_b_o
);

  // Restoring division used only while the table is built.
  function automatic logic [63:0] div_restoring(input logic [63:0] num,
                                                input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    int          b;
    quo = '0;
    rem = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Q31 product rounded half up.
  function automatic logic [63:0] q31_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b + 64'h4000_0000) >> 31;
  endfunction

  // exp(-f) for f in [0,1) in Q31, 24-term series.
  function automatic logic [63:0] exp_frac(input logic [63:0] f);
    logic [63:0] sum;
    logic [63:0] term;
    int          k;
    sum  = 64'h8000_0000;
    term = 64'h8000_0000;
    for (k = 1; k <= 24; k++) begin
      term = div_restoring(q31_mul(term, f), 64'(k));
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // One table entry in Q16.
  function automatic logic [hwps_pkg::GVAL_W-1:0] exp_entry(input logic [31:0] i);
    logic [63:0] e_half;
    logic [63:0] e_one;
    logic [63:0] num;
    logic [63:0] whole;
    logic [63:0] frac;
    logic [63:0] v;
    logic [63:0] rnd;
    int          j;
    e_half = exp_frac(64'h4000_0000);
    e_one  = q31_mul(e_half, e_half);
    num    = 64'(i) * 64'd20;
    whole  = num / EXP_TABLE_DEPTH;
    frac   = ((num % EXP_TABLE_DEPTH) << 31) / EXP_TABLE_DEPTH;
    v      = exp_frac(frac);
    for (j = 0; j < 20; j++) begin
      if (64'(j) < whole) begin
        v = q31_mul(v, e_one);
      end
    end
    rnd = (v + 64'h4000) >> 15;
    return rnd[hwps_pkg::GVAL_W-1:0];
  endfunction

  logic [hwps_pkg::GVAL_W-1:0] rom [EXP_TABLE_DEPTH];

  // Constant table contents.
  for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [hwps_pkg::GVAL_W-1:0] ENTRY = exp_entry(32'(gi));
    assign rom[gi] = ENTRY;
  end

  // Two registered read ports.
  always_ff @(posedge clk_i) begin
    val_a_o <= rom[idx_a_i];
    val_b_o <= rom[idx_b_i];
  end

endmodule

[hw/rtl/hwps_back.sv]
// ----------------------------------------------------------------------------
// Hub weighted pair score back end
// Runs hub loads and pair queries: hub memory, scoring pipeline and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hub_weighted_pair_score_assert.svh"

module hwps_back #(
  parameter int unsigned MAX_HUBS        = 128,
  parameter int unsigned EXP_TABLE_DEPTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [hwps_pkg::COUNT_W-1:0]     hub_count_i,
  input  logic                             q_empty_i,
  input  hwps_pkg::cmd_t                   q_head_i,
  output logic                             q_pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output hwps_pkg::out_item_t              out_item_o
);

  localparam int unsigned ADDR_W = (MAX_HUBS > 1) ? $clog2(MAX_HUBS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_HUBS + 1);
  localparam int unsigned ACC_W  = hwps_pkg::SCORE_W + CNT_W;
  localparam int unsigned IDX_W  = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned DM_W   = IDX_W + 1;
  localparam int unsigned DX_W   = hwps_pkg::DIST_W + DM_W;
  localparam int unsigned TERM_W = 41;
  localparam int unsigned P_W    = 33;
  localparam int unsigned AB_W   = 53;
  localparam int unsigned WSUM_W = 74;
  localparam int unsigned CW     = hwps_pkg::COORD_W;
  localparam int unsigned WW     = hwps_pkg::WEIGHT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOAD  = 2'd1;
  localparam logic [1:0] ST_QUERY = 2'd2;

  // Control state.
  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] n_q, issue_cnt_q;
  logic             out_valid_q;
  hwps_pkg::out_item_t out_item_q;

  logic rd_v_q, sq_v_q, ix_v_q, rom_v_q, p_v_q, ab_v_q, term_v_q;

  // Captured command fields.
  logic [ADDR_W-1:0]    slot_q;
  logic signed [CW-1:0] hx_q, hy_q;
  logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q;

  // Hub memory.
  logic [CW-1:0] hub_x_mem [MAX_HUBS];
  logic [CW-1:0] hub_y_mem [MAX_HUBS];
  logic [WW-1:0] hub_w_mem [MAX_HUBS];
  logic signed [CW-1:0] rd_x_q, rd_y_q;
  logic [WW-1:0]        rd_w_q;

  // Pipeline payload.
  logic [hwps_pkg::SQ_W-1:0] sq_ax_q, sq_ay_q, sq_bx_q, sq_by_q;
  logic [WW-1:0]             w1_q, w2_q, w3_q, w4_q;
  logic [IDX_W-1:0]          ia_q, ib_q;
  logic                      fa_q, fb_q, fa3_q, fb3_q;
  logic [hwps_pkg::GVAL_W-1:0] ga_raw, gb_raw;
  logic [P_W-1:0]            p_q;
  logic [AB_W-1:0]           a_q, b_q;
  logic [TERM_W-1:0]         term_q;
  logic [ACC_W-1:0]          acc_q;

  hwps_pkg::wreq_t w_req;
  hwps_pkg::wrsp_t w_rsp;

  logic        pop, issue, pipe_busy, drained, out_free, finish, mem_we;
  logic [31:0] n_full, slot_ext;
  logic [ADDR_W-1:0] rd_addr;

  logic signed [CW:0]   dax, day, dbx, dby;
  logic signed [33:0]   pax, pay, pbx, pby;
  logic [hwps_pkg::DIST_W-1:0] d2a, d2b;
  logic [DX_W-1:0]      prod_a, prod_b;
  logic [DM_W-1:0]      idxf_a, idxf_b;
  logic [hwps_pkg::GVAL_W-1:0] ga, gb;
  logic [33:0]          prod_g;
  logic [AB_W-1:0]      a_d, b_d;
  logic [WSUM_W-1:0]    wsum;
  logic                 sat;

  // Sequencer decisions.
  always_comb begin
    n_full    = (32'(hub_count_i) > MAX_HUBS) ? 32'(MAX_HUBS) : 32'(hub_count_i);
    slot_ext  = 32'(q_head_i.slot);
    pop       = (state_q == ST_IDLE) && !q_empty_i;
    issue     = (state_q == ST_QUERY) && (issue_cnt_q != n_q);
    pipe_busy = rd_v_q | sq_v_q | ix_v_q | rom_v_q | p_v_q | ab_v_q | term_v_q;
    drained   = (state_q == ST_QUERY) && !issue && !pipe_busy;
    out_free  = !out_valid_q || out_ready_i;
    finish    = drained && out_free;
    mem_we    = (state_q == ST_LOAD) && w_rsp.done;
    rd_addr   = issue_cnt_q[ADDR_W-1:0];

    w_req.start = pop && (q_head_i.op == hwps_pkg::OP_LOAD);
    w_req.x     = q_head_i.hub_x;
    w_req.y     = q_head_i.hub_y;
  end

  assign q_pop_o = pop;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop) begin
          state_d = (q_head_i.op == hwps_pkg::OP_LOAD) ? ST_LOAD : ST_QUERY;
        end
      end
      ST_LOAD: begin
        if (w_rsp.done) begin
          state_d = ST_IDLE;
        end
      end
      ST_QUERY: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers and stage valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      issue_cnt_q <= '0;
      out_valid_q <= 1'b0;
      rd_v_q      <= 1'b0;
      sq_v_q      <= 1'b0;
      ix_v_q      <= 1'b0;
      rom_v_q     <= 1'b0;
      p_v_q       <= 1'b0;
      ab_v_q      <= 1'b0;
      term_v_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop && q_head_i.op == hwps_pkg::OP_QUERY) begin
        n_q         <= n_full[CNT_W-1:0];
        issue_cnt_q <= '0;
      end else if (issue) begin
        issue_cnt_q <= issue_cnt_q + 1'b1;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      rd_v_q   <= issue;
      sq_v_q   <= rd_v_q;
      ix_v_q   <= sq_v_q;
      rom_v_q  <= ix_v_q;
      p_v_q    <= rom_v_q;
      ab_v_q   <= p_v_q;
      term_v_q <= ab_v_q;
    end
  end

  // Command capture.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      slot_q <= slot_ext[ADDR_W-1:0];
      hx_q   <= q_head_i.hub_x;
      hy_q   <= q_head_i.hub_y;
      ax_q   <= q_head_i.a_x;
      ay_q   <= q_head_i.a_y;
      bx_q   <= q_head_i.b_x;
      by_q   <= q_head_i.b_y;
    end
  end

  // Hub memory: one write port for loads, one registered read for the walk.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hub_x_mem[slot_q] <= hx_q;
      hub_y_mem[slot_q] <= hy_q;
      hub_w_mem[slot_q] <= w_rsp.weight;
    end
    rd_x_q <= hub_x_mem[rd_addr];
    rd_y_q <= hub_y_mem[rd_addr];
    rd_w_q <= hub_w_mem[rd_addr];
  end

  hwps_weight u_weight (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (w_req),
    .rsp_o  (w_rsp)
  );

  // Scoring datapath, one hub per cycle.
  always_comb begin
    dax = {ax_q[CW-1], ax_q} - {rd_x_q[CW-1], rd_x_q};
    day = {ay_q[CW-1], ay_q} - {rd_y_q[CW-1], rd_y_q};
    dbx = {bx_q[CW-1], bx_q} - {rd_x_q[CW-1], rd_x_q};
    dby = {by_q[CW-1], by_q} - {rd_y_q[CW-1], rd_y_q};
    pax = 34'(dax) * 34'(dax);
    pay = 34'(day) * 34'(day);
    pbx = 34'(dbx) * 34'(dbx);
    pby = 34'(dby) * 34'(dby);

    d2a    = {1'b0, sq_ax_q} + {1'b0, sq_ay_q};
    d2b    = {1'b0, sq_bx_q} + {1'b0, sq_by_q};
    prod_a = DX_W'(d2a) * DX_W'(EXP_TABLE_DEPTH);
    prod_b = DX_W'(d2b) * DX_W'(EXP_TABLE_DEPTH);
    idxf_a = prod_a[DX_W-1:hwps_pkg::DIST_W];
    idxf_b = prod_b[DX_W-1:hwps_pkg::DIST_W];

    ga     = fa3_q ? '0 : ga_raw;
    gb     = fb3_q ? '0 : gb_raw;
    prod_g = 34'(ga) * 34'(gb);

    a_d  = AB_W'(p_q) * AB_W'(w4_q[WW-1:20]);
    b_d  = AB_W'(p_q) * AB_W'(w4_q[19:0]);
    wsum = {1'b0, a_q, 20'd0} + WSUM_W'(b_q);

    sat = |acc_q[ACC_W-1:hwps_pkg::SCORE_W];
  end

  always_ff @(posedge clk_i) begin
    // Squared distances from both nodes to the hub.
    sq_ax_q <= pax[hwps_pkg::SQ_W-1:0];
    sq_ay_q <= pay[hwps_pkg::SQ_W-1:0];
    sq_bx_q <= pbx[hwps_pkg::SQ_W-1:0];
    sq_by_q <= pby[hwps_pkg::SQ_W-1:0];
    w1_q    <= rd_w_q;
    // Table index and out-of-range flag.
    ia_q <= idxf_a[IDX_W-1:0];
    ib_q <= idxf_b[IDX_W-1:0];
    fa_q <= (idxf_a >= DM_W'(EXP_TABLE_DEPTH));
    fb_q <= (idxf_b >= DM_W'(EXP_TABLE_DEPTH));
    w2_q <= w1_q;
    // Align flags and weight with the table read.
    fa3_q <= fa_q;
    fb3_q <= fb_q;
    w3_q  <= w2_q;
    // Product of both lookups.
    p_q  <= prod_g[P_W-1:0];
    w4_q <= w3_q;
    // Weight scaling split into two partial products.
    a_q <= a_d;
    b_q <= b_d;
    term_q <= wsum[TERM_W+30:31];
    // Accumulator.
    if (pop) begin
      acc_q <= '0;
    end else if (term_v_q) begin
      acc_q <= acc_q + ACC_W'(term_q);
    end
  end

  hwps_exp_rom #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_exp_rom (
    .clk_i   (clk_i),
    .idx_a_i (ia_q),
    .idx_b_i (ib_q),
    .val_a_o (ga_raw),
    .val_b_o (gb_raw)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_item_q.score     <= sat ? hwps_pkg::SCORE_MAX : acc_q[hwps_pkg::SCORE_W-1:0];
      out_item_q.saturated <= sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `HWPS_ASSERT(a_issue_bound, clk_i, rst_ni, issue_cnt_q <= n_q)
  `HWPS_ASSERT_IMP(a_term_in_query, clk_i, rst_ni, term_v_q, state_q == ST_QUERY)
  `HWPS_ASSERT_IMP(a_weight_in_load, clk_i, rst_ni, w_rsp.done, state_q == ST_LOAD)
  `HWPS_ASSERT_NXT(a_hold_when_blocked, clk_i, rst_ni, drained && !out_free,
                   state_q == ST_QUERY)

endmodule

[hw/rtl/hub_weighted_pair_score.sv]
// ----------------------------------------------------------------------------
// Hub weighted pair score
// Loads hub positions with 1/r^4 weights and scores node pairs against them.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake                 Payload
// in       in   in_valid_i / in_ready_o   hwps_pkg::in_item_t
// out      out  out_valid_o / out_ready_i hwps_pkg::out_item_t
// cfg      in   cfg_valid_i / cfg_ready_o hub_count, 8 bits
//
// A load in the back end runs the 40-step weight divider. A query scores n
// hubs, n being hub_count capped at MAX_HUBS, and none when n is zero: the
// hub memory read port walks one hub per cycle into the scoring pipeline.
// Reset clears control state only; the hub memory needs no clearing pass.
// The front end takes transfers while the two-entry queue has room; a result
// waiting in the output register holds the next query at the end of its walk,
// and items behind that query wait in the queue.
`timescale 1ns / 1ps

module hub_weighted_pair_score #(
  parameter int unsigned MAX_HUBS        = 128,
  parameter int unsigned EXP_TABLE_DEPTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  hwps_pkg::in_item_t           in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output hwps_pkg::out_item_t          out_item_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hwps_pkg::COUNT_W-1:0] cfg_data_i
);

  logic [hwps_pkg::COUNT_W-1:0] hub_count_q;
  logic           q_push, q_full, q_pop, q_empty;
  hwps_pkg::cmd_t q_wdata, q_head;

  // Configuration register, written on every cfg transfer.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hub_count_q <= '0;
    end else if (cfg_valid_i) begin
      hub_count_q <= cfg_data_i;
    end
  end

  hwps_front #(
    .MAX_HUBS (MAX_HUBS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  hwps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  hwps_back #(
    .MAX_HUBS        (MAX_HUBS),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hub_count_i (hub_count_q),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// Hub weighted pair score testbench
// Loads hub tables and sends node pair queries through the valid/ready
// channels under several hub counts and flow-control patterns. Each accepted
// item goes into an in-bench copy of the scoring arithmetic. Each result
// transfer is checked against the oldest expected score.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import hwps_pkg::*;

  localparam int unsigned HUB_LIMIT       = 128;
  localparam int unsigned TABLE_DEPTH     = 1024;
  localparam int unsigned ITEMS_PER_PHASE = 139;
  localparam int unsigned SETTLE_CYCLES   = 300;
  localparam int unsigned REPORT_LIMIT    = 10;

  typedef enum int {
    PACE_FREE,
    PACE_SLOW_SEND,
    PACE_SLOW_RECV,
    PACE_BOTH
  } pace_e;

  // Expected pair scores, computed from the hub table as items are accepted.
  class pair_score_board;
    logic [GVAL_W-1:0]         exp_q16 [TABLE_DEPTH];
    logic signed [COORD_W-1:0] hub_x [HUB_LIMIT];
    logic signed [COORD_W-1:0] hub_y [HUB_LIMIT];
    logic [WEIGHT_W-1:0]       hub_w [HUB_LIMIT];
    int unsigned               hub_count;
    out_item_t                 pending_scores [$];
    int unsigned               failures;

    // Q31 product, rounded half up.
    static function longint unsigned q31_mul(longint unsigned a, longint unsigned b);
      return (a * b + 64'h4000_0000) >> 31;
    endfunction

    // exp(-f) for f in [0,1) in Q31, from a 24-term series.
    static function longint unsigned exp_neg_q31(longint unsigned f);
      longint unsigned acc;
      longint unsigned term;
      acc  = 64'h8000_0000;
      term = acc;
      for (int k = 1; k <= 24; k++) begin
        term = q31_mul(term, f) / longint'(k);
        if (k % 2 == 1) acc -= term;
        else acc += term;
      end
      return acc;
    endfunction

    function new();
      longint unsigned e_half;
      longint unsigned e_one;
      longint unsigned num;
      longint unsigned whole;
      longint unsigned frac;
      longint unsigned v;
      e_half = exp_neg_q31(64'h4000_0000);
      e_one  = q31_mul(e_half, e_half);
      // Entry i holds exp(-20*i/depth) in Q16.
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        num   = 20 * i;
        whole = num / TABLE_DEPTH;
        frac  = ((num % TABLE_DEPTH) << 31) / TABLE_DEPTH;
        v     = exp_neg_q31(frac);
        for (longint unsigned j = 0; j < whole; j++) v = q31_mul(v, e_one);
        exp_q16[i] = GVAL_W'((v + 64'h4000) >> 15);
      end
      for (int h = 0; h < HUB_LIMIT; h++) begin
        hub_x[h] = '0;
        hub_y[h] = '0;
        hub_w[h] = '0;
      end
      hub_count = 0;
      failures  = 0;
    endfunction

    // Table lookup of exp(-10*d^2) between a node and hub h.
    function longint unsigned green_at(logic signed [COORD_W-1:0] px,
                                       logic signed [COORD_W-1:0] py, int h);
      longint          dx;
      longint          dy;
      longint unsigned d2;
      longint unsigned idx;
      dx  = longint'(px) - longint'(hub_x[h]);
      dy  = longint'(py) - longint'(hub_y[h]);
      d2  = dx * dx + dy * dy;
      idx = (d2 * TABLE_DEPTH) >> 33;
      if (idx >= TABLE_DEPTH) return 0;
      return exp_q16[idx];
    endfunction

    // Applies an accepted input transfer: a load updates the hub table, a query
    // queues its expected score.
    function void note_item(in_item_t it);
      longint unsigned r2;
      bit [127:0]      wide;
      longint unsigned n;
      longint unsigned p;
      longint unsigned acc;
      out_item_t       want;
      if (it.mode == MODE_LOAD) begin
        // Weight is floor(2^79 / r2^2) with r2 floored at 2^-12.
        r2 = longint'(it.hub_x_value) * longint'(it.hub_x_value) +
             longint'(it.hub_y_value) * longint'(it.hub_y_value);
        if (r2 < RSQ_FLOOR) r2 = RSQ_FLOOR;
        wide = r2;
        wide = wide * wide;
        hub_x[it.hub_slot] = it.hub_x_value;
        hub_y[it.hub_slot] = it.hub_y_value;
        hub_w[it.hub_slot] = WEIGHT_W'((128'd1 << 79) / wide);
      end else begin
        n   = (hub_count > HUB_LIMIT) ? HUB_LIMIT : hub_count;
        acc = 0;
        for (int h = 0; h < n; h++) begin
          p    = green_at(it.node_a_x, it.node_a_y, h) * green_at(it.node_b_x, it.node_b_y, h);
          wide = 128'(p) * 128'(hub_w[h]);
          acc += 64'(wide >> 31);
        end
        want.saturated = (acc > SCORE_MAX);
        want.score     = want.saturated ? SCORE_MAX : acc[SCORE_W-1:0];
        pending_scores.push_back(want);
      end
    endfunction

    // Compares one result transfer with the oldest expected score.
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_scores.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected result: score %0d saturated %0d", got.score, got.saturated);
        return;
      end
      want = pending_scores.pop_front();
      if (got.score !== want.score || got.saturated !== want.saturated) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("score mismatch: expected %0d/%0d, actual %0d/%0d",
                   want.score, want.saturated, got.score, got.saturated);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_item_t            in_item_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_item_t           out_item_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [COUNT_W-1:0]  cfg_data_i;

  pair_score_board board;
  int unsigned     send_pct;
  int unsigned     recv_pct;

  hub_weighted_pair_score #(
    .MAX_HUBS        (HUB_LIMIT),
    .EXP_TABLE_DEPTH (TABLE_DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: check each transfer and stall at random.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_item_o);
    out_ready_i <= ($urandom_range(99) >= recv_pct);
  end

  // Sends one item. Valid stays high after the transfer so that a following
  // item can go out back to back; it is lowered only for an idle gap.
  task automatic send_item(in_item_t it);
    if (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_pct);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(it);
  endtask

  // Holds the sender off until every expected score has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending_scores.size() != 0) @(posedge clk_i);
  endtask

  // Writes the hub count once the block has gone quiet.
  task automatic write_hub_count(logic [COUNT_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.hub_count = value;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_item_t make_load(int unsigned slot, logic signed [COORD_W-1:0] x,
                                         logic signed [COORD_W-1:0] y);
    in_item_t it;
    it             = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    it.mode        = MODE_LOAD;
    it.hub_slot    = SLOT_W'(slot);
    it.hub_x_value = x;
    it.hub_y_value = y;
    return it;
  endfunction

  function automatic in_item_t make_query(logic signed [COORD_W-1:0] ax,
                                          logic signed [COORD_W-1:0] ay,
                                          logic signed [COORD_W-1:0] bx,
                                          logic signed [COORD_W-1:0] by);
    in_item_t it;
    it          = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    it.mode     = MODE_QUERY;
    it.node_a_x = ax;
    it.node_a_y = ay;
    it.node_b_x = bx;
    it.node_b_y = by;
    return it;
  endfunction

  // Random mix: mostly queries, some loads, and hubs now and then close to
  // the origin, where the weight floor can apply.
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned slot;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(99) < 70) begin
      it.mode = MODE_QUERY;
      if ($urandom_range(4) == 0) begin
        slot        = $urandom_range(HUB_LIMIT - 1);
        it.node_a_x = board.hub_x[slot];
        it.node_a_y = board.hub_y[slot];
      end
    end else begin
      it.mode = MODE_LOAD;
      if ($urandom_range(5) == 0) begin
        it.hub_x_value = COORD_W'($urandom_range(2047)) - COORD_W'(1024);
        it.hub_y_value = COORD_W'($urandom_range(2047)) - COORD_W'(1024);
      end
    end
    return it;
  endfunction

  initial begin
    logic [COUNT_W-1:0] phase_counts [12];
    pace_e              pace;

    board       = new();
    send_pct    = 0;
    recv_pct    = 0;
    rst_ni      = 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With no hubs counted the score is zero.
    send_item(make_query(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff));

    // Hub loads at the coordinate extremes, below and at the radius floor.
    send_item(make_load(0, 16'sd0, 16'sd0));
    send_item(make_load(1, 16'sh8000, 16'sh8000));
    send_item(make_load(2, 16'sh7fff, 16'sh7fff));
    send_item(make_load(3, 16'sh8000, 16'sh7fff));
    send_item(make_load(4, 16'sd1000, -16'sd1));
    send_item(make_load(5, 16'sd1024, 16'sd0));
    send_item(make_load(HUB_LIMIT - 1, 16'sh7fff, 16'sh8000));

    // Fill the rest of the table so any hub count reads written entries.
    for (int s = 6; s < HUB_LIMIT - 1; s++)
      send_item(make_load(s, COORD_W'($urandom), COORD_W'($urandom)));

    write_hub_count(COUNT_W'(6));
    send_item(make_query(16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_item(make_query(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff));
    send_item(make_query(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff));
    send_item(make_query(16'sh7fff, 16'sh8000, 16'sd1024, 16'sd0));

    // Counts above the table size are capped.
    write_hub_count(COUNT_W'(255));
    send_item(make_query(16'sd0, 16'sd0, 16'sd1000, -16'sd1));
    send_item(make_query(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff));

    // Random phases, each with its own hub count and flow-control pattern.
    phase_counts = '{8'd128, 8'd0, 8'd1, 8'd255, 8'd17, 8'd200, 8'd129,
                     8'd0, 8'd64, 8'd2, 8'd0, 8'd128};
    phase_counts[7]  = COUNT_W'($urandom_range(HUB_LIMIT));
    phase_counts[10] = COUNT_W'($urandom_range(HUB_LIMIT));
    for (int ph = 0; ph < 12; ph++) begin
      write_hub_count(phase_counts[ph]);
      pace = pace_e'(ph % 4);
      case (pace)
        PACE_FREE: begin
          send_pct = 0;
          recv_pct = 0;
        end
        PACE_SLOW_SEND: begin
          send_pct = 82;
          recv_pct = 0;
        end
        PACE_SLOW_RECV: begin
          send_pct = 0;
          recv_pct = 82;
        end
        default: begin
          send_pct = 18;
          recv_pct = 18;
        end
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k == ITEMS_PER_PHASE / 2 && pace == PACE_SLOW_SEND) drain_results();
        send_item(random_item());
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.failures == 0 && board.pending_scores.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
